// ----- rtl/depth_to_gradient_color_assert.svh -----
// Assertion macros shared by the depth colormap RTL.
// Each use needs clk_i and rst_ni in scope; no other dependencies.
`ifndef DEPTH_TO_GRADIENT_COLOR_ASSERT_SVH
`define DEPTH_TO_GRADIENT_COLOR_ASSERT_SVH

// Checked on every rising edge, muted while reset is asserted
`define DGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, including during reset
`define DGC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/dgc_pkg.sv -----
// Shared types, constants and color helpers for the depth colormap.
// No dependencies; used by every module of the block.
`default_nettype none

package dgc_pkg;

  // Depth and window register width
  localparam int unsigned DEPTH_BITS     = 16;
  // Width of the depth field on the input stream
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned IN_W           = (DEPTH_BITS < SAMPLE_W) ? DEPTH_BITS : SAMPLE_W;
  // Range used when the window is empty or inverted (one meter)
  localparam int unsigned FALLBACK_RANGE = 1000;
  localparam int unsigned RNG_W          = (DEPTH_BITS > 10) ? DEPTH_BITS : 10;

  // Gradient position: 2 segment bits over a 14-bit blend weight
  localparam int unsigned K_BITS    = 14;
  localparam int unsigned T_BITS    = K_BITS + 2;
  localparam int unsigned K_ONE     = 1 << K_BITS;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned BLEND_W   = COLOR_W + K_BITS + 1;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_LOW  = 1'b0,
    REG_DEPTH_HIGH = 1'b1
  } cfg_reg_e;

  typedef logic [COLOR_W-1:0] color_t;

  // red sits in the low byte
  typedef struct packed {
    color_t blue;
    color_t green;
    color_t red;
  } rgb_t;

  // Word moving down the divider chain
  typedef struct packed {
    logic              invalid;
    logic              sat;
    logic [RNG_W-1:0]  rng;
    logic [RNG_W-1:0]  rem;
    logic [T_BITS-1:0] quo;
  } div_word_t;

  localparam rgb_t INVALID_COLOR = '{red: 8'd18, green: 8'd20, blue: 8'd26};
  localparam logic [2:0] LAST_STOP = 3'd4;

  // Five gradient stops
  function automatic rgb_t stop_color(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd90};
      3'd1:    c = '{red: 8'd0,   green: 8'd180, blue: 8'd200};
      3'd2:    c = '{red: 8'd0,   green: 8'd220, blue: 8'd60};
      3'd3:    c = '{red: 8'd250, green: 8'd220, blue: 8'd30};
      default: c = '{red: 8'd240, green: 8'd40,  blue: 8'd40};
    endcase
    return c;
  endfunction

  // (a*(1-k) + b*k) in Q0.14, truncated
  function automatic color_t blend_chan(input color_t a, input color_t b,
                                        input logic [K_BITS-1:0] k);
    logic [K_BITS:0]    wa;
    logic [BLEND_W-1:0] sum;
    wa  = (K_BITS+1)'(K_ONE) - {1'b0, k};
    sum = BLEND_W'(a) * BLEND_W'(wa) + BLEND_W'(b) * BLEND_W'(k);
    return sum[K_BITS +: COLOR_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dgc_front.sv -----
// Input stage: window offset, range selection and saturation check.
// Depends on dgc_pkg.
`default_nettype none

module dgc_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               en_i,
  input  wire                               valid_i,
  input  wire [dgc_pkg::SAMPLE_W-1:0]       depth_mm_i,
  input  wire [dgc_pkg::DEPTH_BITS-1:0]     depth_low_i,
  input  wire [dgc_pkg::DEPTH_BITS-1:0]     depth_high_i,
  output logic                              valid_o,
  output dgc_pkg::div_word_t                word_o
);
  import dgc_pkg::*;

  logic [DEPTH_BITS-1:0] d;
  logic [DEPTH_BITS-1:0] diff;
  logic [RNG_W-1:0]      rng;
  logic                  sat;
  logic                  valid_q;
  div_word_t             word_d, word_q;

  // Offset into the window and the divisor
  always_comb begin
    d    = DEPTH_BITS'(depth_mm_i[IN_W-1:0]);
    rng  = (depth_high_i > depth_low_i) ? RNG_W'(depth_high_i - depth_low_i)
                                        : RNG_W'(FALLBACK_RANGE);
    diff = (d > depth_low_i) ? (d - depth_low_i) : '0;
    // t reaches 1.0 exactly when the offset reaches the range
    sat  = RNG_W'(diff) >= rng;
    word_d.invalid = (d == '0);
    word_d.sat     = sat;
    word_d.rng     = rng;
    word_d.rem     = sat ? '0 : RNG_W'(diff);
    word_d.quo     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/dgc_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per word.
// Depends on dgc_pkg.
`default_nettype none

module dgc_div_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire                 valid_i,
  input  dgc_pkg::div_word_t  word_i,
  output logic                valid_o,
  output dgc_pkg::div_word_t  word_o
);
  import dgc_pkg::*;

  logic [RNG_W:0] rem2;
  logic [RNG_W:0] rng_x;
  logic           ge;
  logic           valid_q;
  div_word_t      word_d, word_q;

  // Shift remainder, trial subtract
  always_comb begin
    rem2   = {word_i.rem, 1'b0};
    rng_x  = {1'b0, word_i.rng};
    ge     = rem2 >= rng_x;
    word_d = word_i;
    word_d.rem = ge ? RNG_W'(rem2 - rng_x) : rem2[RNG_W-1:0];
    word_d.quo = {word_i.quo[T_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/dgc_blend.sv -----
// Color stage: picks the segment stops and blends each channel.
// Depends on dgc_pkg.
`default_nettype none

module dgc_blend (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire                 valid_i,
  input  dgc_pkg::div_word_t  word_i,
  output logic                valid_o,
  output dgc_pkg::rgb_t       rgb_o
);
  import dgc_pkg::*;

  logic [1:0]        seg;
  logic [K_BITS-1:0] k;
  rgb_t              ca, cb, rgb_d, rgb_q;
  logic              valid_q;

  always_comb begin
    seg = word_i.quo[T_BITS-1 -: 2];
    k   = word_i.quo[K_BITS-1:0];
    ca  = stop_color({1'b0, seg});
    cb  = stop_color(3'({1'b0, seg}) + 3'd1);
    if (word_i.invalid) begin
      rgb_d = INVALID_COLOR;
    end else if (word_i.sat) begin
      rgb_d = stop_color(LAST_STOP);
    end else begin
      rgb_d.red   = blend_chan(ca.red,   cb.red,   k);
      rgb_d.green = blend_chan(ca.green, cb.green, k);
      rgb_d.blue  = blend_chan(ca.blue,  cb.blue,  k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

`default_nettype wire

// ----- rtl/depth_to_gradient_color.sv -----
// Depth-to-color top level: config registers, division chain, blend, output skid.
// Depends on dgc_pkg, dgc_front, dgc_div_cell, dgc_blend and the assertion header.
//
// Usage:
// - Slave stream: one depth sample in millimeters per word (0 = no reading).
// - Master stream: one RGB word per sample, same order, red in the low byte.
// - Window registers (low, high) are written through the cfg port, by the user only
//   while idle (unchecked); an empty or inverted window spans one meter from low.
// - One word accepted per clock while s_axis_tready is high. Each word passes one
//   front stage, 16 division cells (one quotient bit each), one blend stage and
//   the output register on its way from accept to tvalid.
// - On a downstream stall the pipeline keeps running until the word behind the
//   held output lands in the skid register; then s_axis_tready drops and the
//   whole chain holds. Nothing is lost or repeated.
// - Reset clears every valid flag, loads low = 0 and high = 4000, and leaves
//   the stream empty with s_axis_tready high.
`default_nettype none

module depth_to_gradient_color (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Config write port
  input  wire                               cfg_we_i,
  input  wire [dgc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [dgc_pkg::DEPTH_BITS-1:0]     cfg_data_i,
  // Depth in
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [15:0]                        s_axis_tdata,  // [15:0] depth_mm
  // Color out
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [23:0]                       m_axis_tdata   // [7:0] red, [15:8] green,
                                                           // [23:16] blue
);
  import dgc_pkg::*;

  `include "depth_to_gradient_color_assert.svh"

  logic [DEPTH_BITS-1:0] depth_low_q, depth_high_q;
  logic                  en;

  logic                  chain_valid [T_BITS+1];
  div_word_t             chain_word  [T_BITS+1];

  logic                  bl_valid;
  rgb_t                  bl_rgb;

  logic                  o_valid_q, sk_valid_q;
  rgb_t                  o_rgb_q, sk_rgb_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_low_q  <= '0;
      depth_high_q <= DEPTH_BITS'(4000);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEPTH_LOW:  depth_low_q  <= cfg_data_i;
        REG_DEPTH_HIGH: depth_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole chain advances while the skid is empty
  assign en            = !sk_valid_q;
  assign s_axis_tready = en;

  dgc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .depth_mm_i   (s_axis_tdata),
    .depth_low_i  (depth_low_q),
    .depth_high_i (depth_high_q),
    .valid_o      (chain_valid[0]),
    .word_o       (chain_word[0])
  );

  // Division chain, one quotient bit per cell
  for (genvar i = 0; i < T_BITS; i++) begin : g_cell
    dgc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .word_i  (chain_word[i]),
      .valid_o (chain_valid[i+1]),
      .word_o  (chain_word[i+1])
    );
  end

  dgc_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[T_BITS]),
    .word_i  (chain_word[T_BITS]),
    .valid_o (bl_valid),
    .rgb_o   (bl_rgb)
  );

  // Output register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (en) begin
      if (bl_valid) begin
        if (!o_valid_q || m_axis_tready) begin
          o_valid_q <= 1'b1;
        end else begin
          sk_valid_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end else if (m_axis_tready) begin
      sk_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (bl_valid) begin
        if (!o_valid_q || m_axis_tready) begin
          o_rgb_q <= bl_rgb;
        end else begin
          sk_rgb_q <= bl_rgb;
        end
      end
    end else if (m_axis_tready) begin
      o_rgb_q <= sk_rgb_q;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_rgb_q;

  // Checks
  `DGC_ASSERT(a_skid_behind_out, sk_valid_q |-> o_valid_q, "skid full with output empty")
  `DGC_ASSERT(a_skid_held, sk_valid_q && !m_axis_tready |=> sk_valid_q, "skid word dropped")
  `DGC_ASSERT(a_skid_cause, $rose(sk_valid_q) |-> $past(o_valid_q && !m_axis_tready), "skid filled without stall")
  `DGC_ASSERT(a_ready_skid, s_axis_tready == !sk_valid_q, "ready out of step with skid")
  `DGC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !(o_valid_q || sk_valid_q), "busy after reset")

endmodule

`default_nettype wire
